// File: hdl/bmpm_pkg.sv
package bmpm_pkg;

  localparam int WINDOWS      = 4;
  localparam int WIN_W        = 2;
  localparam int OFFSET_W     = 14;
  localparam int BANK_W       = 7;
  localparam int PHYS_W       = BANK_W + OFFSET_W;
  localparam int PAGE_W       = 8;
  localparam int COUNT_W      = 8;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [PAGE_W-1:0]  PAGE_RESET_BASE = 8'h80;
  localparam logic [COUNT_W-1:0] BANK_COUNT_RESET = 8'd128;
  localparam int                 EXT_BIT = 7;

  // Lock port bit taken by each window
  localparam int LOCK_BIT_W0 = 6;
  localparam int LOCK_BIT_W1 = 4;
  localparam int LOCK_BIT_W2 = 5;
  localparam int LOCK_BIT_W3 = 7;

  localparam logic REG_BANK_COUNT = 1'b0;

  typedef enum logic [2:0] {
    MODE_PAGE_WR  = 3'd0,
    MODE_LOCK_WR  = 3'd1,
    MODE_RD       = 3'd2,
    MODE_WR       = 3'd3,
    MODE_READBACK = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  window_index;
    logic [7:0]  write_value;
    logic [15:0] cpu_address;
  } req_t;

  typedef struct packed {
    logic [20:0] physical_address;
    logic [7:0]  page_readback;
  } rsp_t;

  typedef struct packed {
    logic               start;
    logic [BANK_W-1:0]  dividend;
    logic [COUNT_W-1:0] divisor;
  } rem_cmd_t;

  typedef struct packed {
    logic              busy;
    logic [BANK_W-1:0] remainder;
  } rem_sts_t;

endpackage

// File: hdl/bmpm_remdiv.sv
module bmpm_remdiv (
  input  logic               clk,
  input  logic               rst,
  input  bmpm_pkg::rem_cmd_t cmd,
  output bmpm_pkg::rem_sts_t sts
);
  import bmpm_pkg::*;

  localparam int STEP_W = $clog2(BANK_W);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [BANK_W-1:0]  dvd;
  logic [COUNT_W-1:0] dsr;
  logic [COUNT_W-1:0] rem;

  logic [COUNT_W:0]   trial;
  logic               fits;
  logic [COUNT_W:0]   diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, dvd[BANK_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      step <= STEP_W'(BANK_W - 1);
    end else if (busy) begin
      step <= step - 1'b1;
      if (step == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd <= cmd.dividend;
      dsr <= cmd.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[BANK_W-2:0], 1'b0};
      rem <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
    end
  end

  assign sts.busy      = busy;
  assign sts.remainder = rem[BANK_W-1:0];

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && dsr != '0 |-> rem < dsr)
    else $error("remainder not below divisor");

  a_no_restart_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.start)
    else $error("remainder unit restarted while busy");

endmodule

// File: hdl/banked_memory_page_mapper.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  bmpm_pkg::req_t
// rsp       out        rsp_valid/rsp_stall  bmpm_pkg::rsp_t
// apb       in         psel/penable/pready  bank_count at byte address 0
//
// An item is taken in one cycle and decoded in the next. Page, lock and readback
// items, legacy-mode accesses and extended ones with bank_count 0 finish there.
// Other extended accesses run the bank modulo through the bit-serial remainder
// unit, one bit per cycle over 7 bits. One item is in flight; req_stall is high
// until its result is in the output register. Synchronous reset restores the page
// registers, sets all locks and bank_count to 128. A stalled result holds.
module banked_memory_page_mapper (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  bmpm_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output bmpm_pkg::rsp_t                 rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bmpm_pkg::PADDR_W-1:0]   paddr,
  input  logic [bmpm_pkg::PDATA_W-1:0]   pwdata,
  output logic [bmpm_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import bmpm_pkg::*;

  state_t             state, state_next;
  req_t               item;
  logic [PAGE_W-1:0]  page_regs [WINDOWS];
  logic [WINDOWS-1:0] locks;
  logic [COUNT_W-1:0] bank_count;

  rem_cmd_t           rem_cmd;
  rem_sts_t           rem_sts;

  logic               accept;
  logic               slot_free;
  logic               load_rsp;
  logic               apply;
  logic               is_access;
  logic               is_ext;
  logic [WIN_W-1:0]   sel_win;
  logic [PAGE_W-1:0]  pg;
  logic [BANK_W-1:0]  legacy_bank;
  logic [BANK_W-1:0]  bank;
  rsp_t               rsp_next;

  bmpm_remdiv u_remdiv (
    .clk (clk),
    .rst (rst),
    .cmd (rem_cmd),
    .sts (rem_sts)
  );

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_BANK_COUNT)
                ? {{(PDATA_W-COUNT_W){1'b0}}, bank_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_count <= BANK_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_BANK_COUNT) begin
      bank_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign req_stall = state != ST_IDLE;
  assign accept    = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;

  // Bank resolution
  assign is_access   = item.mode == MODE_RD || item.mode == MODE_WR;
  assign sel_win     = is_access ? item.cpu_address[15:14] : item.window_index;
  assign pg          = page_regs[sel_win];
  assign is_ext      = pg[EXT_BIT];
  assign legacy_bank = (item.mode == MODE_WR || locks[sel_win])
                     ? {4'b0, pg[2:0]} : {4'b0, pg[6:4]};
  always_comb begin
    if (!is_ext) begin
      bank = legacy_bank;
    end else if (bank_count == '0) begin
      bank = '0;
    end else begin
      bank = rem_sts.remainder;
    end
  end

  always_comb begin
    rsp_next = '0;
    if (is_access) begin
      rsp_next.physical_address = {bank, item.cpu_address[OFFSET_W-1:0]};
    end else if (item.mode == MODE_READBACK) begin
      rsp_next.page_readback = pg;
    end
  end

  always_comb begin
    state_next       = state;
    load_rsp         = 1'b0;
    apply            = 1'b0;
    rem_cmd.start    = 1'b0;
    rem_cmd.dividend = pg[BANK_W-1:0];
    rem_cmd.divisor  = bank_count;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (is_access && is_ext && bank_count != '0) begin
          rem_cmd.start = 1'b1;
          state_next    = ST_WAIT;
        end else if (slot_free) begin
          load_rsp   = 1'b1;
          apply      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (!rem_sts.busy && slot_free) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOWS; i++) begin
        page_regs[i] <= PAGE_RESET_BASE + PAGE_W'(i);
      end
      locks <= '1;
    end else if (apply) begin
      case (item.mode)
        MODE_PAGE_WR: page_regs[item.window_index] <= item.write_value;
        MODE_LOCK_WR: begin
          locks[0] <= item.write_value[LOCK_BIT_W0];
          locks[1] <= item.write_value[LOCK_BIT_W1];
          locks[2] <= item.write_value[LOCK_BIT_W2];
          locks[3] <= item.write_value[LOCK_BIT_W3];
        end
        default: ;
      endcase
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted item not decoded next cycle");

  a_busy_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    rem_sts.busy |-> state == ST_WAIT)
    else $error("remainder unit busy outside wait");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    load_rsp |-> slot_free)
    else $error("result loaded over a pending transfer");

endmodule

// File: tb/sv/bmpm_checker.sv
module bmpm_checker
  import bmpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  req_t               req,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  localparam logic [PADDR_W-1:0] BANK_COUNT_ADDR = PADDR_W'(4 * REG_BANK_COUNT);

  logic [PAGE_W-1:0]  page_reg [WINDOWS];
  logic               win_lock [WINDOWS];
  logic [COUNT_W-1:0] bank_cnt;
  rsp_t               expected_rsp [$];

  task automatic report_mismatch(input string what);
    if (fail_count < 100) $display("%0t: %s", $time, what);
    fail_count++;
  endtask

  // Banks are resolved at access time, so lock and bank count changes apply at once
  function automatic logic [BANK_W-1:0] resolve_bank(input logic [WIN_W-1:0] win,
                                                     input logic is_write);
    logic [PAGE_W-1:0] pg;
    pg = page_reg[win];
    if (pg[EXT_BIT]) begin
      if (bank_cnt == '0) return '0;
      return BANK_W'({1'b0, pg[BANK_W-1:0]} % bank_cnt);
    end
    if (is_write || win_lock[win]) return BANK_W'(pg[2:0]);
    return BANK_W'(pg[6:4]);
  endfunction

  function automatic rsp_t apply_item(input req_t r);
    rsp_t o;
    o = '0;
    case (r.mode)
      MODE_PAGE_WR: page_reg[r.window_index] = r.write_value;
      MODE_LOCK_WR: begin
        win_lock[0] = r.write_value[LOCK_BIT_W0];
        win_lock[1] = r.write_value[LOCK_BIT_W1];
        win_lock[2] = r.write_value[LOCK_BIT_W2];
        win_lock[3] = r.write_value[LOCK_BIT_W3];
      end
      MODE_RD, MODE_WR: begin
        o.physical_address = {resolve_bank(r.cpu_address[OFFSET_W +: WIN_W],
                                           r.mode == MODE_WR),
                              r.cpu_address[OFFSET_W-1:0]};
      end
      MODE_READBACK: o.page_readback = page_reg[r.window_index];
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int w = 0; w < WINDOWS; w++) begin
        page_reg[w] = PAGE_RESET_BASE + PAGE_W'(w);
        win_lock[w] = 1'b1;
      end
      bank_cnt = BANK_COUNT_RESET;
      expected_rsp.delete();
    end else begin
      if (psel && penable && pready && paddr == BANK_COUNT_ADDR) begin
        if (pwrite) begin
          bank_cnt = pwdata[COUNT_W-1:0];
        end else if (prdata !== PDATA_W'(bank_cnt)) begin
          report_mismatch($sformatf("bank_count read %h, want %h", prdata, bank_cnt));
        end
      end
      // retire the oldest expectation before queueing the new transfer
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.physical_address !== want.physical_address)
            report_mismatch($sformatf("physical_address %h, want %h",
                                      rsp.physical_address, want.physical_address));
          if (rsp.page_readback !== want.page_readback)
            report_mismatch($sformatf("page_readback %h, want %h",
                                      rsp.page_readback, want.page_readback));
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(apply_item(req));
    end
    pending = expected_rsp.size();
  end

endmodule

// File: tb/sv/tb.sv
module tb;
  import bmpm_pkg::*;

  localparam logic [PADDR_W-1:0] BANK_COUNT_ADDR = PADDR_W'(4 * REG_BANK_COUNT);
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 154;
  localparam int HOLD_CYCLES = 400;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  req_t               req;
  logic               rsp_valid;
  logic               rsp_stall;
  rsp_t               rsp;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;

  int                 idle_pct;
  int                 stall_pct;
  logic               hold_wanted;
  logic               hold_taken;
  int                 hold_left;
  logic [COUNT_W-1:0] bank_plan [0:PHASES-1];

  banked_memory_page_mapper uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bmpm_checker mapper_check (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #6 clk = 1'b1;
    #6;
  end

  initial begin
    #(12 * 200000);
    $display("tb failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the mapper backs up
  initial begin
    rsp_stall = 1'b0;
    hold_taken = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        rsp_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else if (hold_wanted && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic req_t make_item(input logic [2:0] m, input logic [1:0] win,
                                     input logic [7:0] val, input logic [15:0] addr);
    req_t r;
    r.mode = m;
    r.window_index = win;
    r.write_value = val;
    r.cpu_address = addr;
    return r;
  endfunction

  function automatic req_t random_item();
    req_t r;
    int pick;
    r = make_item(3'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
    pick = $urandom_range(99);
    if (pick < 55) begin
      r.mode = $urandom_range(1) ? MODE_WR : MODE_RD;
    end else if (pick < 72) begin
      r.mode = MODE_PAGE_WR;
      // favour extended pages so the bank modulo gets plenty of work
      if ($urandom_range(1)) r.write_value[EXT_BIT] = 1'b1;
    end else if (pick < 80) begin
      r.mode = MODE_LOCK_WR;
    end else if (pick < 94) begin
      r.mode = MODE_READBACK;
    end else begin
      r.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
                            input logic [PDATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_wanted = 1'b0;
    bank_plan = '{8'd16, 8'd0, 8'd255, 8'd48, 8'd112, 8'd200, 8'd128, 8'd64};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset pages and locks, bank count 128
    for (int w = 0; w < WINDOWS; w++)
      send(make_item(MODE_READBACK, 2'(w), 8'hFF, 16'hFFFF));
    send(make_item(MODE_RD, 2'd3, 8'h00, 16'h0000));
    send(make_item(MODE_WR, 2'd0, 8'hFF, 16'hFFFF));
    // legacy page, locked: reads follow the write bank
    send(make_item(MODE_PAGE_WR, 2'd1, 8'h75, 16'h0000));
    send(make_item(MODE_RD, 2'd0, 8'h00, 16'h4000));
    send(make_item(MODE_WR, 2'd0, 8'h00, 16'h7FFF));
    // all locks clear: read and write banks split
    send(make_item(MODE_LOCK_WR, 2'd2, 8'h00, 16'h0000));
    send(make_item(MODE_RD, 2'd0, 8'h00, 16'h4123));
    send(make_item(MODE_WR, 2'd0, 8'h00, 16'h4123));
    // only window 1 locked
    send(make_item(MODE_LOCK_WR, 2'd0, 8'h10, 16'hFFFF));
    send(make_item(MODE_RD, 2'd0, 8'h00, 16'h4000));
    send(make_item(MODE_PAGE_WR, 2'd2, 8'hFF, 16'h0000));
    send(make_item(MODE_RD, 2'd0, 8'h00, 16'hBFFF));
    send(make_item(MODE_PAGE_WR, 2'd3, 8'h00, 16'hFFFF));
    send(make_item(MODE_RD, 2'd0, 8'h00, 16'hC000));
    send(make_item(MODE_LOCK_WR, 2'd1, 8'hFF, 16'h0000));
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
      send(make_item(3'(m), 2'd3, 8'hFF, 16'hFFFF));
    send(make_item(MODE_READBACK, 2'd2, 8'h00, 16'h0000));

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      apb_access(1'b1, BANK_COUNT_ADDR, PDATA_W'(bank_plan[p]));
      apb_access(1'b0, BANK_COUNT_ADDR, '0);
      case (p % 4)
        0: begin idle_pct = 0; stall_pct <= 0; end
        1: begin idle_pct = 72; stall_pct <= 0; end
        2: begin idle_pct = 0; stall_pct <= 72; end
        default: begin idle_pct = 13; stall_pct <= 13; end
      endcase
      if (p == 0) hold_wanted <= 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send(random_item());
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/bmpm_pkg.sv
hdl/bmpm_remdiv.sv
hdl/banked_memory_page_mapper.sv
tb/sv/bmpm_checker.sv
tb/sv/tb.sv
